>>> src/ipr_pkg.sv
// shared types, constants and helpers of the ips patch record parser
`timescale 1ns / 1ps
`default_nettype none

package ipr_pkg;

  // field widths
  localparam int ByteW     = 8;
  localparam int SizeW     = 25;
  localparam int RecAddrW  = 24;
  localparam int LenW      = 16;
  localparam int PosW      = 3;
  localparam int KindW     = 2;

  // output tdata: address, value, fill_count, final_size, padded to whole bytes
  localparam int OutFieldsW = SizeW + ByteW + LenW + SizeW;
  localparam int OutDataW   = ((OutFieldsW + 7) / 8) * 8;

  // result queue
  localparam int FifoDepth  = 4;
  localparam int FifoPtrW   = 2;
  localparam int FifoCountW = 3;

  // address that ends the record list ("EOF")
  localparam logic [RecAddrW-1:0] EofMark = 24'h454F46;

  // header byte positions
  localparam logic [PosW-1:0] HdrLastPos = 3'd4;

  typedef enum logic [KindW-1:0] {
    KIND_WRITE      = 2'd0,
    KIND_FILL       = 2'd1,
    KIND_DONE       = 2'd2,
    KIND_BAD_HEADER = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    PH_HEADER,
    PH_BAD,
    PH_ADDR,
    PH_LEN,
    PH_DATA,
    PH_FILL,
    PH_TRUNC,
    PH_DONE
  } phase_t;

  typedef struct packed {
    kind_t              kind;
    logic [SizeW-1:0]   address;
    logic [ByteW-1:0]   value;
    logic [LenW-1:0]    fill_count;
    logic [SizeW-1:0]   final_size;
    logic               last_of_run;
  } result_t;

  // expected header text "PATCH"
  function automatic logic [ByteW-1:0] hdr_byte(input logic [PosW-1:0] pos);
    logic [ByteW-1:0] b;
    case (pos)
      3'd0:    b = 8'h50;
      3'd1:    b = 8'h41;
      3'd2:    b = 8'h54;
      3'd3:    b = 8'h43;
      3'd4:    b = 8'h48;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

>>> src/ipr_parser.sv
// record parser: phase tracking, record fields and result generation per byte
`timescale 1ns / 1ps
`default_nettype none

module ipr_parser (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          go,
  input  wire  [ipr_pkg::ByteW-1:0]    in_byte,
  input  wire                          in_last,
  input  wire  [ipr_pkg::SizeW-1:0]    image_size,
  output logic [1:0]                   res_count,
  output ipr_pkg::result_t             res0,
  output ipr_pkg::result_t             res1
);
  import ipr_pkg::*;

  phase_t                phase, phase_next;
  logic [PosW-1:0]       field_position, field_position_next;
  logic [RecAddrW-1:0]   record_address, record_address_next;
  logic [LenW-1:0]       record_length, record_length_next;
  logic [LenW-1:0]       data_offset, data_offset_next;
  logic [LenW-1:0]       repeat_count, repeat_count_next;
  logic [SizeW-1:0]      greatest_end, greatest_end_next;
  logic [RecAddrW-1:0]   truncate_offset, truncate_offset_next;
  logic                  truncate_valid, truncate_valid_next;

  // per-byte work
  result_t               prim, fin;
  logic                  prim_v, fin_v;
  logic [SizeW-1:0]      rec_end;
  logic                  rec_end_v;
  logic [LenW-1:0]       offset_inc;
  logic [SizeW-1:0]      grown_size;
  logic [SizeW-1:0]      out_size;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_HEADER;
      field_position  <= '0;
      record_address  <= '0;
      record_length   <= '0;
      data_offset     <= '0;
      repeat_count    <= '0;
      greatest_end    <= '0;
      truncate_offset <= '0;
      truncate_valid  <= 1'b0;
    end else if (go) begin
      phase           <= phase_next;
      field_position  <= field_position_next;
      record_address  <= record_address_next;
      record_length   <= record_length_next;
      data_offset     <= data_offset_next;
      repeat_count    <= repeat_count_next;
      greatest_end    <= greatest_end_next;
      truncate_offset <= truncate_offset_next;
      truncate_valid  <= truncate_valid_next;
    end
  end

  // next state and results
  always_comb begin
    phase_next           = phase;
    field_position_next  = field_position;
    record_address_next  = record_address;
    record_length_next   = record_length;
    data_offset_next     = data_offset;
    repeat_count_next    = repeat_count;
    greatest_end_next    = greatest_end;
    truncate_offset_next = truncate_offset;
    truncate_valid_next  = truncate_valid;
    prim                 = '0;
    prim_v               = 1'b0;
    fin                  = '0;
    fin_v                = 1'b0;
    rec_end              = '0;
    rec_end_v            = 1'b0;
    offset_inc           = data_offset + LenW'(1);
    grown_size           = '0;
    out_size             = '0;

    case (phase)
      PH_HEADER: begin
        if (in_byte != hdr_byte(field_position)) begin
          phase_next  = PH_BAD;
          prim.kind   = KIND_BAD_HEADER;
          prim_v      = 1'b1;
        end else if (field_position == HdrLastPos) begin
          phase_next          = PH_ADDR;
          field_position_next = '0;
        end else begin
          field_position_next = field_position + PosW'(1);
        end
      end
      PH_ADDR: begin
        record_address_next = {record_address[RecAddrW-ByteW-1:0], in_byte};
        if (field_position >= PosW'(2)) begin
          field_position_next = '0;
          if (record_address_next == EofMark) begin
            phase_next           = PH_TRUNC;
            truncate_offset_next = '0;
          end else begin
            phase_next         = PH_LEN;
            record_length_next = '0;
          end
        end else begin
          field_position_next = field_position + PosW'(1);
        end
      end
      PH_LEN: begin
        record_length_next = {record_length[LenW-ByteW-1:0], in_byte};
        if (field_position >= PosW'(1)) begin
          field_position_next = '0;
          data_offset_next    = '0;
          repeat_count_next   = '0;
          phase_next          = (record_length_next == '0) ? PH_FILL : PH_DATA;
        end else begin
          field_position_next = field_position + PosW'(1);
        end
      end
      PH_DATA: begin
        prim.kind        = KIND_WRITE;
        prim.address     = {1'b0, record_address} + {{(SizeW-LenW){1'b0}}, data_offset};
        prim.value       = in_byte;
        prim_v           = 1'b1;
        data_offset_next = offset_inc;
        if (offset_inc >= record_length) begin
          rec_end             = {1'b0, record_address} +
                                {{(SizeW-LenW){1'b0}}, record_length};
          rec_end_v           = 1'b1;
          phase_next          = PH_ADDR;
          field_position_next = '0;
          record_address_next = '0;
        end
      end
      PH_FILL: begin
        if (field_position < PosW'(2)) begin
          repeat_count_next   = {repeat_count[LenW-ByteW-1:0], in_byte};
          field_position_next = field_position + PosW'(1);
        end else begin
          prim.kind           = KIND_FILL;
          prim.address        = {1'b0, record_address};
          prim.value          = in_byte;
          prim.fill_count     = repeat_count;
          prim_v              = 1'b1;
          rec_end             = {1'b0, record_address} +
                                {{(SizeW-LenW){1'b0}}, repeat_count};
          rec_end_v           = 1'b1;
          phase_next          = PH_ADDR;
          field_position_next = '0;
          record_address_next = '0;
        end
      end
      PH_TRUNC: begin
        truncate_offset_next = {truncate_offset[RecAddrW-ByteW-1:0], in_byte};
        if (field_position >= PosW'(2)) begin
          truncate_valid_next = 1'b1;
          phase_next          = PH_DONE;
          field_position_next = '0;
        end else begin
          field_position_next = field_position + PosW'(1);
        end
      end
      default: begin
      end
    endcase

    // track the greatest record end
    if (rec_end_v && (rec_end > greatest_end)) begin
      greatest_end_next = rec_end;
    end

    // final size: grown image, cut at the truncate offset
    grown_size = (greatest_end_next > image_size) ? greatest_end_next : image_size;
    out_size   = (truncate_valid_next && (grown_size > {1'b0, truncate_offset_next})) ?
                 {1'b0, truncate_offset_next} : grown_size;

    // end of stream result, then back to the reset state
    if (in_last) begin
      if (phase_next == PH_HEADER) begin
        fin.kind = KIND_BAD_HEADER;
        fin_v    = 1'b1;
      end else if (phase_next != PH_BAD) begin
        fin.kind       = KIND_DONE;
        fin.final_size = out_size;
        fin_v          = 1'b1;
      end
      phase_next           = PH_HEADER;
      field_position_next  = '0;
      record_address_next  = '0;
      record_length_next   = '0;
      data_offset_next     = '0;
      repeat_count_next    = '0;
      greatest_end_next    = '0;
      truncate_offset_next = '0;
      truncate_valid_next  = 1'b0;
    end

    prim.last_of_run = !fin_v;
    fin.last_of_run  = 1'b1;
  end

  // pack into result slots
  assign res_count = go ? ({1'b0, prim_v} + {1'b0, fin_v}) : 2'd0;
  assign res0      = prim_v ? prim : fin;
  assign res1      = fin;

  // a second result only comes with the end of the stream
  assert property (@(posedge clk) disable iff (rst)
    res_count == 2'd2 |-> in_last && prim.kind != KIND_BAD_HEADER)
    else $error("two results without a clean end of stream");

  // the end of the stream returns the parser to its reset state
  assert property (@(posedge clk) disable iff (rst)
    go && in_last |=> phase == PH_HEADER && greatest_end == '0 && !truncate_valid)
    else $error("state not cleared after end of stream");

  // after a bad header nothing more comes out
  assert property (@(posedge clk) disable iff (rst)
    go && phase == PH_BAD |-> res_count == 2'd0)
    else $error("result after bad header");

endmodule

`default_nettype wire

>>> src/ips_patch_record_parser_top.sv
// top level of the ips patch record parser: input register, parser, result queue
//
//  channel   dir  signals                              contents
//  s_axis    in   tvalid tready tdata[7:0] tlast       patch byte, tlast = end of stream
//  m_axis    out  tvalid tready tdata[79:0] tuser tlast one result, tuser = kind
//  cfg       in   valid ready data[24:0]               image size register write
//
//  one patch byte per cycle while the queue has room; a byte waits in the input
//  register until the parser takes it, then its results enter the output queue.
//  the last byte of a stream may give two results, taken one per cycle while
//  m_axis_tready is high from a four-entry queue; input stalls while fewer than two
//  entries are free. rst clears all control state and sets the image size to zero.
`timescale 1ns / 1ps
`default_nettype none

module ips_patch_record_parser_top (
  input  wire                            clk,
  input  wire                            rst,
  // patch bytes
  input  wire                            s_axis_tvalid,
  output logic                           s_axis_tready,
  input  wire  [7:0]                     s_axis_tdata,   // [7:0] patch_byte
  input  wire                            s_axis_tlast,   // stream_end
  // results
  output logic                           m_axis_tvalid,
  input  wire                            m_axis_tready,
  // [24:0] address, [32:25] value, [48:33] fill_count, [73:49] final_size, rest zero
  output logic [ipr_pkg::OutDataW-1:0]   m_axis_tdata,
  output logic [ipr_pkg::KindW-1:0]      m_axis_tuser,   // [1:0] kind
  output logic                           m_axis_tlast,   // last_of_run
  // configuration
  input  wire                            cfg_valid,
  output logic                           cfg_ready,
  input  wire  [ipr_pkg::SizeW-1:0]      cfg_data        // image_size
);
  import ipr_pkg::*;

  logic                   in_valid;
  logic [ByteW-1:0]       in_byte;
  logic                   in_last;
  logic                   advance;
  logic [SizeW-1:0]       image_size;

  logic [1:0]             res_count;
  result_t                res0, res1;

  result_t                fifo [FifoDepth];
  logic [FifoPtrW-1:0]    head, tail;
  logic [FifoCountW-1:0]  count, count_next;
  logic                   pop;
  result_t                head_res;

  // configuration register
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_size <= '0;
    end else if (cfg_valid) begin
      image_size <= cfg_data;
    end
  end

  // input register
  assign advance       = in_valid && (count <= FifoCountW'(FifoDepth - 2));
  assign s_axis_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_byte <= s_axis_tdata;
      in_last <= s_axis_tlast;
    end
  end

  // parser
  ipr_parser u_parser (
    .clk        (clk),
    .rst        (rst),
    .go         (advance),
    .in_byte    (in_byte),
    .in_last    (in_last),
    .image_size (image_size),
    .res_count  (res_count),
    .res0       (res0),
    .res1       (res1)
  );

  // result queue control
  assign pop        = m_axis_tvalid && m_axis_tready;
  assign count_next = count + FifoCountW'(res_count) - FifoCountW'(pop);

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      head  <= head + FifoPtrW'(pop);
      tail  <= tail + FifoPtrW'(res_count);
      count <= count_next;
    end
  end

  // result queue storage
  always_ff @(posedge clk) begin
    if (res_count != 2'd0) begin
      fifo[tail] <= res0;
    end
    if (res_count == 2'd2) begin
      fifo[tail + FifoPtrW'(1)] <= res1;
    end
  end

  // output side
  assign head_res      = fifo[head];
  assign m_axis_tvalid = (count != '0);
  assign m_axis_tuser  = head_res.kind;
  assign m_axis_tlast  = head_res.last_of_run;
  assign m_axis_tdata  = {{(OutDataW-OutFieldsW){1'b0}}, head_res.final_size,
                          head_res.fill_count, head_res.value, head_res.address};

  // queue never overfills
  assert property (@(posedge clk) disable iff (rst)
    count <= FifoCountW'(FifoDepth))
    else $error("result queue overflow");

  // finish and bad-header results close the run of their byte
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tuser == KIND_DONE || m_axis_tuser == KIND_BAD_HEADER)
    |-> m_axis_tlast)
    else $error("closing result without last_of_run");

  // a held byte stays in the input register until the parser takes it
  assert property (@(posedge clk) disable iff (rst)
    in_valid && !advance |=> in_valid && $stable(in_byte) && $stable(in_last))
    else $error("pending byte lost");

endmodule

`default_nettype wire
